[rtl/kva_pkg.sv]
package kva_pkg;

  localparam int ADDR_BITS = 48;

  localparam logic [1:0] REQ_MAP       = 2'd0;
  localparam logic [1:0] REQ_UNMAP     = 2'd1;
  localparam logic [1:0] REQ_TRANSLATE = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN   = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_DUPLICATE   = 3'd1;
  localparam logic [2:0] ST_OUT_OF_VA   = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd3;
  localparam logic [2:0] ST_NOT_MAPPED  = 3'd4;

  localparam int          CFG_IDX_BITS       = 3;
  localparam int          CFG_BITS           = 48;
  localparam logic [2:0]  CFG_DIRECT_PA_START = 3'd0;
  localparam logic [2:0]  CFG_DIRECT_PA_END   = 3'd1;
  localparam logic [2:0]  CFG_DIRECT_VA_BASE  = 3'd2;
  localparam logic [2:0]  CFG_DYN_VA_START    = 3'd3;
  localparam logic [2:0]  CFG_DYN_VA_END      = 3'd4;

  localparam int PAGES_BITS = 21;
  localparam int LEN_BITS   = 32;
  localparam int FLAG_BITS  = 8;
  localparam int OUT_BITS   = 48;

  // one classified request handed from the front end to the table engine
  typedef struct packed {
    logic [1:0]            req_type;
    logic [63:0]           addr;
    logic [63:0]           page_addr;
    logic [15:0]           offset;
    logic [PAGES_BITS-1:0] pages;
    logic [FLAG_BITS-1:0]  flags;
    logic                  direct;
    logic [63:0]           direct_addr;
  } kva_cmd_t;

  typedef struct packed {
    logic [OUT_BITS-1:0]   result_addr;
    logic [OUT_BITS-1:0]   cmd_pa;
    logic [OUT_BITS-1:0]   cmd_va;
    logic [PAGES_BITS-1:0] cmd_pages;
    logic [FLAG_BITS-1:0]  cmd_flags;
    logic                  direct_hit;
    logic [2:0]            status;
  } kva_res_t;

endpackage

[rtl/kva_ram.sv]
module kva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/kva_front.sv]
module kva_front import kva_pkg::*; #(
  parameter int PAGE_SHIFT = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  logic [47:0]           in_address,
  input  logic [LEN_BITS-1:0]   in_length,
  input  logic [FLAG_BITS-1:0]  in_map_flags,
  input  logic                  in_force_map,
  input  logic [ADDR_BITS-1:0]  direct_pa_start,
  input  logic [ADDR_BITS-1:0]  direct_pa_end,
  input  logic [ADDR_BITS-1:0]  direct_va_base,
  output logic                  q_valid,
  input  logic                  q_pop,
  output kva_cmd_t              q_cmd
);

  localparam int QD = 2;

  logic [ADDR_BITS-1:0] addr, pg, off, vadiff, dsize, dres;
  logic [LEN_BITS+PAGE_SHIFT:0] pg_sum;
  logic                 win_ok, hit;
  kva_cmd_t             cmd;
  kva_cmd_t             q_r [QD];
  logic                 rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 push;

  always_comb begin
    addr   = in_address[ADDR_BITS-1:0];
    off    = addr & ADDR_BITS'((64'd1 << PAGE_SHIFT) - 64'd1);
    pg     = addr & ~ADDR_BITS'((64'd1 << PAGE_SHIFT) - 64'd1);
    pg_sum = (LEN_BITS+PAGE_SHIFT+1)'(in_length)
           + (LEN_BITS+PAGE_SHIFT+1)'(off[PAGE_SHIFT-1:0])
           + (LEN_BITS+PAGE_SHIFT+1)'((64'd1 << PAGE_SHIFT) - 64'd1);
    win_ok = direct_pa_end > direct_pa_start;
    dsize  = direct_pa_end - direct_pa_start;
    vadiff = pg - direct_va_base;
    hit    = 1'b0;
    dres   = '0;
    unique case (in_req_type)
      REQ_MAP: begin
        hit  = (pg >= direct_pa_start) && (pg < direct_pa_end) && !in_force_map;
        dres = direct_va_base + (pg - direct_pa_start);
      end
      REQ_UNMAP: begin
        hit  = win_ok && (pg >= direct_va_base) && (vadiff < dsize);
        dres = direct_pa_start + vadiff;
      end
      REQ_TRANSLATE: begin
        hit  = win_ok && (pg >= direct_va_base) && (vadiff < dsize);
        dres = direct_pa_start + (addr - direct_va_base);
      end
      default: begin
        hit  = 1'b0;
        dres = '0;
      end
    endcase
    cmd             = '0;
    cmd.req_type    = in_req_type;
    cmd.addr        = 64'(addr);
    cmd.page_addr   = 64'(pg);
    cmd.offset      = 16'(off);
    cmd.pages       = pg_sum[PAGE_SHIFT +: PAGES_BITS];
    cmd.flags       = in_map_flags;
    cmd.direct      = hit;
    cmd.direct_addr = 64'(dres);
  end

  // requests of unknown type are dropped here
  assign in_stall = (cnt_r == 2'(QD));
  assign push     = in_valid && !in_stall && (in_req_type != REQ_UNKNOWN);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rd_r];

  always_comb begin
    rd_nxt  = rd_r ^ (q_pop && q_valid);
    wr_nxt  = wr_r ^ push;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_r] <= cmd;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QD))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(QD) && !q_pop) |=> cnt_r == 2'(QD))
    else $error("full queue lost an entry");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0) |-> !(q_pop && q_valid))
    else $error("pop from empty queue");

endmodule

[rtl/kva_engine.sv]
module kva_engine import kva_pkg::*; #(
  parameter int ENTRIES    = 128,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  kva_cmd_t             q_cmd,
  input  logic [ADDR_BITS-1:0] dynamic_va_start,
  input  logic [ADDR_BITS-1:0] dynamic_va_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kva_res_t             res
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int PW = ADDR_BITS - PAGE_SHIFT;
  localparam int EW = 2 * PW + PAGES_BITS + FLAG_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_SHWR  = 3'd4;
  localparam logic [2:0] S_PUT   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]           st_r, st_nxt;
  logic [CW-1:0]        used_r, used_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [ADDR_BITS-1:0] virt_r, virt_nxt;
  kva_cmd_t             c_r, c_nxt;
  kva_res_t             res_r, res_nxt;
  logic                 ov_r, ov_nxt;

  logic                 we;
  logic [IW-1:0]        waddr, raddr;
  logic [EW-1:0]        wdata, rdata;
  logic [PW-1:0]        e_pp, e_vp;
  logic [PAGES_BITS-1:0] e_cnt;
  logic [FLAG_BITS-1:0] e_fl;

  logic [ADDR_BITS-1:0] pa, va, rv, rlen, bytes, vend, vstart, off;
  logic [ADDR_BITS:0]   vsum;

  kva_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

  assign {e_pp, e_vp, e_cnt, e_fl} = rdata;
  assign out_valid = ov_r;
  assign res       = res_r;
  assign q_pop     = (st_r == S_IDLE) && q_valid && !ov_r;

  always_comb begin
    pa     = c_r.page_addr[ADDR_BITS-1:0];
    va     = c_r.page_addr[ADDR_BITS-1:0];
    off    = ADDR_BITS'(c_r.offset);
    bytes  = ADDR_BITS'(c_r.pages) << PAGE_SHIFT;
    rv     = ADDR_BITS'({e_vp, {PAGE_SHIFT{1'b0}}});
    rlen   = ADDR_BITS'(e_cnt) << PAGE_SHIFT;
    vsum   = {1'b0, virt_r} + {1'b0, bytes};
    vend   = vsum[ADDR_BITS-1:0];
    vstart = (dynamic_va_start + ADDR_BITS'((64'd1 << PAGE_SHIFT) - 64'd1))
           & ~ADDR_BITS'((64'd1 << PAGE_SHIFT) - 64'd1);

    st_nxt   = st_r;
    used_nxt = used_r;
    n_nxt    = n_r;
    k_nxt    = k_r;
    virt_nxt = virt_r;
    c_nxt    = c_r;
    res_nxt  = res_r;
    ov_nxt   = ov_r && out_stall;
    we       = 1'b0;
    waddr    = n_r[IW-1:0];
    wdata    = rdata;
    raddr    = n_r[IW-1:0];

    unique case (st_r)
      S_IDLE: begin
        if (q_pop) begin
          c_nxt    = q_cmd;
          n_nxt    = '0;
          virt_nxt = vstart;
          res_nxt  = '0;
          raddr    = '0;
          st_nxt   = S_READ;
        end
      end
      S_READ: begin
        // entry n_r is read this cycle
        st_nxt = S_CHECK;
        if (c_r.direct) begin
          res_nxt.direct_hit = 1'b1;
          res_nxt.status     = ST_OK;
          unique case (c_r.req_type)
            REQ_MAP: begin
              res_nxt.result_addr = OUT_BITS'(c_r.direct_addr[ADDR_BITS-1:0] + off);
              res_nxt.cmd_pa      = OUT_BITS'(pa);
              res_nxt.cmd_va      = OUT_BITS'(c_r.direct_addr[ADDR_BITS-1:0]);
              res_nxt.cmd_pages   = c_r.pages;
              res_nxt.cmd_flags   = c_r.flags;
            end
            REQ_UNMAP: begin
              res_nxt.cmd_pa    = OUT_BITS'(c_r.direct_addr[ADDR_BITS-1:0]);
              res_nxt.cmd_va    = OUT_BITS'(va);
              res_nxt.cmd_pages = c_r.pages;
            end
            default: res_nxt.result_addr = OUT_BITS'(c_r.direct_addr[ADDR_BITS-1:0]);
          endcase
          st_nxt = S_DONE;
        end
      end
      S_CHECK: begin
        raddr = n_r[IW-1:0];
        if (n_r >= used_r) begin
          // end of table reached
          unique case (c_r.req_type)
            REQ_MAP: st_nxt = S_PUT;
            default: begin
              res_nxt.status = ST_NOT_MAPPED;
              st_nxt         = S_DONE;
            end
          endcase
        end else begin
          unique case (c_r.req_type)
            REQ_MAP: begin
              // the fit test uses the wrapped end; a carry past the top is left
              // for the region end check
              if (vend <= rv) begin
                st_nxt = S_PUT;
              end else if (e_pp == pa[ADDR_BITS-1:PAGE_SHIFT] && e_cnt == c_r.pages) begin
                res_nxt.status = ST_DUPLICATE;
                st_nxt         = S_DONE;
              end else begin
                virt_nxt = rv + rlen;
                n_nxt    = n_r + 1'b1;
                raddr    = IW'(n_r + 1'b1);
                st_nxt   = S_READ;
              end
            end
            REQ_UNMAP: begin
              if (e_vp == va[ADDR_BITS-1:PAGE_SHIFT] && e_cnt == c_r.pages) begin
                res_nxt.cmd_pa    = OUT_BITS'(ADDR_BITS'({e_pp, {PAGE_SHIFT{1'b0}}}));
                res_nxt.cmd_va    = OUT_BITS'(va);
                res_nxt.cmd_pages = c_r.pages;
                res_nxt.cmd_flags = e_fl;
                k_nxt             = n_r;
                raddr             = IW'(n_r + 1'b1);
                st_nxt            = S_SHIFT;
              end else begin
                n_nxt  = n_r + 1'b1;
                raddr  = IW'(n_r + 1'b1);
                st_nxt = S_READ;
              end
            end
            default: begin
              if (!(va < rv || (va - rv) >= rlen)) begin
                res_nxt.result_addr = OUT_BITS'(ADDR_BITS'({e_pp, {PAGE_SHIFT{1'b0}}})
                                    + (c_r.addr[ADDR_BITS-1:0] - rv));
                st_nxt = S_DONE;
              end else begin
                n_nxt  = n_r + 1'b1;
                raddr  = IW'(n_r + 1'b1);
                st_nxt = S_READ;
              end
            end
          endcase
        end
      end
      S_SHIFT: begin
        // unmap moves entries down one; map moves them up from the top
        if (c_r.req_type == REQ_UNMAP) begin
          if (k_r + 1'b1 >= used_r) begin
            used_nxt = used_r - 1'b1;
            st_nxt   = S_DONE;
          end else begin
            raddr  = IW'(k_r + 1'b1);
            st_nxt = S_SHWR;
          end
        end else begin
          if (k_r <= n_r) begin
            st_nxt = S_SHWR;
          end else begin
            raddr  = IW'(k_r - 1'b1);
            st_nxt = S_SHWR;
          end
        end
      end
      S_SHWR: begin
        if (c_r.req_type == REQ_UNMAP) begin
          we     = 1'b1;
          waddr  = k_r[IW-1:0];
          k_nxt  = k_r + 1'b1;
          st_nxt = S_SHIFT;
        end else if (k_r <= n_r) begin
          we       = 1'b1;
          waddr    = n_r[IW-1:0];
          wdata    = {pa[ADDR_BITS-1:PAGE_SHIFT], virt_r[ADDR_BITS-1:PAGE_SHIFT],
                      c_r.pages, c_r.flags};
          used_nxt = used_r + 1'b1;
          res_nxt.result_addr = OUT_BITS'(virt_r + off);
          res_nxt.cmd_pa      = OUT_BITS'(pa);
          res_nxt.cmd_va      = OUT_BITS'(virt_r);
          res_nxt.cmd_pages   = c_r.pages;
          res_nxt.cmd_flags   = c_r.flags;
          st_nxt              = S_DONE;
        end else begin
          we     = 1'b1;
          waddr  = k_r[IW-1:0];
          k_nxt  = k_r - 1'b1;
          st_nxt = S_SHIFT;
        end
      end
      S_PUT: begin
        if (vsum >= {1'b0, dynamic_va_end}) begin
          res_nxt.status = ST_OUT_OF_VA;
          st_nxt         = S_DONE;
        end else if (used_r >= CW'(ENTRIES)) begin
          res_nxt.status = ST_TABLE_FULL;
          st_nxt         = S_DONE;
        end else begin
          k_nxt  = used_r;
          st_nxt = S_SHIFT;
        end
      end
      S_DONE: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      used_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      used_r <= used_nxt;
      ov_r   <= ov_nxt;
    end
    n_r    <= n_nxt;
    k_r    <= k_nxt;
    virt_r <= virt_nxt;
    c_r    <= c_nxt;
    res_r  <= res_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) used_r <= CW'(ENTRIES))
    else $error("run count above table depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(res_r)))
    else $error("held result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |=> (used_r == $past(used_r)))
    else $error("run count moved while idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (st_r == S_SHWR))
    else $error("table written outside shift");

endmodule

[rtl/kernel_va_window_allocator.sv]
// channel   direction  handshake          payload
// in_       input      in_valid/in_stall  req_type address length map_flags force_map
// out_      output     out_valid/out_stall result_addr cmd_pa cmd_va cmd_pages cmd_flags
//                                         direct_hit status
// cfg_      input      cfg_valid/cfg_ready cfg_index cfg_data
//
// a request visits S_READ and S_CHECK for each run walked, then S_SHIFT and S_SHWR for each
// run shifted on insert or remove; walk and shift together cover at most the runs in use,
// so the work per request grows with ENTRIES, set by the one read port of the run table
// a two-entry queue lets the front end take requests while the engine walks the table
// rst_n is synchronous: it empties the table and restores the register defaults
// out_stall holds the finished result; the engine then waits before taking the next request
module kernel_va_window_allocator import kva_pkg::*; #(
  parameter int ENTRIES    = 128,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_req_type,
  input  logic [47:0]             in_address,
  input  logic [LEN_BITS-1:0]     in_length,
  input  logic [FLAG_BITS-1:0]    in_map_flags,
  input  logic                    in_force_map,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OUT_BITS-1:0]     out_result_addr,
  output logic [OUT_BITS-1:0]     out_cmd_pa,
  output logic [OUT_BITS-1:0]     out_cmd_va,
  output logic [PAGES_BITS-1:0]   out_cmd_pages,
  output logic [FLAG_BITS-1:0]    out_cmd_flags,
  output logic                    out_direct_hit,
  output logic [2:0]              out_status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data
);

  // configuration registers
  logic [ADDR_BITS-1:0] dpa_start_r, dpa_end_r, dva_base_r, dyn_start_r, dyn_end_r;
  logic                 q_valid, q_pop;
  kva_cmd_t             q_cmd;
  kva_res_t             res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpa_start_r <= '0;
      dpa_end_r   <= ADDR_BITS'(64'd1073741824);
      dva_base_r  <= ADDR_BITS'(64'd3221225472);
      dyn_start_r <= ADDR_BITS'(64'd1073741824);
      dyn_end_r   <= ADDR_BITS'(64'd2147483648);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DIRECT_PA_START: dpa_start_r <= ADDR_BITS'(cfg_data);
        CFG_DIRECT_PA_END:   dpa_end_r   <= ADDR_BITS'(cfg_data);
        CFG_DIRECT_VA_BASE:  dva_base_r  <= ADDR_BITS'(cfg_data);
        CFG_DYN_VA_START:    dyn_start_r <= ADDR_BITS'(cfg_data);
        CFG_DYN_VA_END:      dyn_end_r   <= ADDR_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // front end: page split, page count, direct window decision
  kva_front #(.PAGE_SHIFT(PAGE_SHIFT)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_address(in_address), .in_length(in_length),
    .in_map_flags(in_map_flags), .in_force_map(in_force_map),
    .direct_pa_start(dpa_start_r), .direct_pa_end(dpa_end_r),
    .direct_va_base(dva_base_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

  // back end: sorted run table walk, insert and remove
  kva_engine #(.ENTRIES(ENTRIES), .PAGE_SHIFT(PAGE_SHIFT)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .dynamic_va_start(dyn_start_r), .dynamic_va_end(dyn_end_r),
    .out_valid(out_valid), .out_stall(out_stall), .res(res));

  assign out_result_addr = res.result_addr;
  assign out_cmd_pa      = res.cmd_pa;
  assign out_cmd_va      = res.cmd_va;
  assign out_cmd_pages   = res.cmd_pages;
  assign out_cmd_flags   = res.cmd_flags;
  assign out_direct_hit  = res.direct_hit;
  assign out_status      = res.status;

endmodule

[tb/kva_checker.sv]
module kva_checker import kva_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [1:0]              in_req_type,
  input  logic [47:0]             in_address,
  input  logic [LEN_BITS-1:0]     in_length,
  input  logic [FLAG_BITS-1:0]    in_map_flags,
  input  logic                    in_force_map,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [OUT_BITS-1:0]     out_result_addr,
  input  logic [OUT_BITS-1:0]     out_cmd_pa,
  input  logic [OUT_BITS-1:0]     out_cmd_va,
  input  logic [PAGES_BITS-1:0]   out_cmd_pages,
  input  logic [FLAG_BITS-1:0]    out_cmd_flags,
  input  logic                    out_direct_hit,
  input  logic [2:0]              out_status,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  output int                      fail_count,
  output int                      awaiting
);

  localparam int          RUNS  = 128;
  localparam logic [63:0] AMASK = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] OFS   = 64'hFFF;

  logic [63:0] win_pa_start, win_pa_end, win_va_base, dyn_start, dyn_end;
  logic [63:0] run_pa [RUNS];
  logic [63:0] run_va [RUNS];
  logic [20:0] run_cnt [RUNS];
  logic [7:0]  run_fl [RUNS];
  int          run_used;
  kva_res_t    expected_q [$];

  assign awaiting = expected_q.size();

  function automatic kva_res_t mk(logic [63:0] ra, logic [63:0] pa, logic [63:0] va,
                                  logic [63:0] pages, logic [7:0] fl, logic hit,
                                  logic [2:0] st);
    kva_res_t r;
    r.result_addr = ra[47:0];
    r.cmd_pa      = pa[47:0];
    r.cmd_va      = va[47:0];
    r.cmd_pages   = pages[20:0];
    r.cmd_flags   = fl;
    r.direct_hit  = hit;
    r.status      = st;
    return r;
  endfunction

  function automatic bit in_window_va(logic [63:0] va);
    if (win_pa_end <= win_pa_start) return 0;
    return va >= win_va_base && (va - win_va_base) < (win_pa_end - win_pa_start);
  endfunction

  // updates the run table and returns the answer to one request
  function automatic kva_res_t allocate(logic [1:0] kind, logic [47:0] addr,
                                        logic [31:0] len, logic [7:0] fl, logic force_it);
    logic [63:0] a, pg, off, size, bytes, virt, rv, va, pa;
    int n, k;
    a = {16'd0, addr};
    pg = a & ~OFS;
    off = a & OFS;
    size = (({32'd0, len} + off + OFS) >> 12) & 64'h1F_FFFF;
    bytes = size << 12;
    if (kind == REQ_MAP) begin
      if (pg >= win_pa_start && pg < win_pa_end && !force_it) begin
        va = (win_va_base + (pg - win_pa_start)) & AMASK;
        return mk((va + off) & AMASK, pg, va, size, fl, 1'b1, ST_OK);
      end
      virt = ((dyn_start + OFS) & ~OFS) & AMASK;
      for (n = 0; n < run_used; n++) begin
        rv = (run_va[n] << 12) & AMASK;
        if (((virt + bytes) & AMASK) <= rv && virt + bytes >= virt) break;
        if (run_pa[n] == (pg >> 12) && {43'd0, run_cnt[n]} == size)
          return mk(0, 0, 0, 0, 0, 1'b0, ST_DUPLICATE);
        virt = (rv + ({43'd0, run_cnt[n]} << 12)) & AMASK;
      end
      if (virt + bytes >= dyn_end) return mk(0, 0, 0, 0, 0, 1'b0, ST_OUT_OF_VA);
      if (run_used >= RUNS) return mk(0, 0, 0, 0, 0, 1'b0, ST_TABLE_FULL);
      for (k = run_used; k > n; k--) begin
        run_pa[k] = run_pa[k-1];
        run_va[k] = run_va[k-1];
        run_cnt[k] = run_cnt[k-1];
        run_fl[k] = run_fl[k-1];
      end
      run_pa[n] = pg >> 12;
      run_va[n] = virt >> 12;
      run_cnt[n] = size[20:0];
      run_fl[n] = fl;
      run_used++;
      return mk((virt + off) & AMASK, pg, virt, size, fl, 1'b0, ST_OK);
    end
    if (kind == REQ_UNMAP) begin
      if (in_window_va(pg)) begin
        pa = (win_pa_start + (pg - win_va_base)) & AMASK;
        return mk(0, pa, pg, size, 0, 1'b1, ST_OK);
      end
      for (n = 0; n < run_used; n++) begin
        if (run_va[n] == (pg >> 12) && {43'd0, run_cnt[n]} == size) begin
          pa = (run_pa[n] << 12) & AMASK;
          fl = run_fl[n];
          for (k = n; k + 1 < run_used; k++) begin
            run_pa[k] = run_pa[k+1];
            run_va[k] = run_va[k+1];
            run_cnt[k] = run_cnt[k+1];
            run_fl[k] = run_fl[k+1];
          end
          run_used--;
          return mk(0, pa, pg, size, fl, 1'b0, ST_OK);
        end
      end
      return mk(0, 0, 0, 0, 0, 1'b0, ST_NOT_MAPPED);
    end
    // translate
    if (in_window_va(pg))
      return mk((win_pa_start + (a - win_va_base)) & AMASK, 0, 0, 0, 0, 1'b1, ST_OK);
    for (n = 0; n < run_used; n++) begin
      rv = (run_va[n] << 12) & AMASK;
      if (pg < rv || pg - rv >= ({43'd0, run_cnt[n]} << 12)) continue;
      return mk(((run_pa[n] << 12) + (a - rv)) & AMASK, 0, 0, 0, 0, 1'b0, ST_OK);
    end
    return mk(0, 0, 0, 0, 0, 1'b0, ST_NOT_MAPPED);
  endfunction

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    kva_res_t want;
    if (!rst_n) begin
      win_pa_start <= 64'd0;
      win_pa_end   <= 64'h4000_0000;
      win_va_base  <= 64'hC000_0000;
      dyn_start    <= 64'h4000_0000;
      dyn_end      <= 64'h8000_0000;
      run_used     = 0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIRECT_PA_START: win_pa_start <= {16'd0, cfg_data};
          CFG_DIRECT_PA_END:   win_pa_end   <= {16'd0, cfg_data};
          CFG_DIRECT_VA_BASE:  win_va_base  <= {16'd0, cfg_data};
          CFG_DYN_VA_START:    dyn_start    <= {16'd0, cfg_data};
          CFG_DYN_VA_END:      dyn_end      <= {16'd0, cfg_data};
          default: ;
        endcase
      end
      // compare before pushing so a same-edge request cannot be its own result
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 64'd1, 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_result_addr !== want.result_addr)
            report("result_addr", out_result_addr, want.result_addr);
          if (out_cmd_pa !== want.cmd_pa) report("cmd_pa", out_cmd_pa, want.cmd_pa);
          if (out_cmd_va !== want.cmd_va) report("cmd_va", out_cmd_va, want.cmd_va);
          if (out_cmd_pages !== want.cmd_pages)
            report("cmd_pages", out_cmd_pages, want.cmd_pages);
          if (out_cmd_flags !== want.cmd_flags)
            report("cmd_flags", out_cmd_flags, want.cmd_flags);
          if (out_direct_hit !== want.direct_hit)
            report("direct_hit", out_direct_hit, want.direct_hit);
          if (out_status !== want.status) report("status", out_status, want.status);
        end
      end
      if (in_valid && !in_stall && in_req_type != REQ_UNKNOWN)
        expected_q.push_back(allocate(in_req_type, in_address, in_length,
                                      in_map_flags, in_force_map));
    end
  end

endmodule

[tb/tb_top.sv]
module tb_top;
  import kva_pkg::*;

  localparam int         IDLE_LIMIT  = 5000;
  localparam int         SETTLE      = 600;

  typedef struct {
    logic [47:0] va;
    logic [20:0] pages;
  } live_map_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_req_type = REQ_MAP;
  logic [47:0] in_address = 0;
  logic [LEN_BITS-1:0] in_length = 0;
  logic [FLAG_BITS-1:0] in_map_flags = 0;
  logic in_force_map = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [OUT_BITS-1:0] out_result_addr, out_cmd_pa, out_cmd_va;
  logic [PAGES_BITS-1:0] out_cmd_pages;
  logic [FLAG_BITS-1:0] out_cmd_flags;
  logic out_direct_hit;
  logic [2:0] out_status;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_DIRECT_PA_START;
  logic [CFG_BITS-1:0] cfg_data = 0;

  int fail_count, awaiting;
  logic in_took = 0, out_took = 0, cfg_took = 0;
  int idle_cycles = 0;
  bit no_gaps = 0;
  live_map_t live_maps [$];

  // window settings as last written, used to aim requests
  logic [47:0] cur_pa_start = 48'd0, cur_pa_end = 48'h4000_0000;
  logic [47:0] cur_va_base = 48'hC000_0000;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  kernel_va_window_allocator dut (.*);

  kva_checker chk (.*);

  // handshake flags: right-hand sides read the values from before the edge
  always @(posedge clk) begin
    in_took  <= in_valid && !in_stall;
    out_took <= out_valid && !out_stall;
    cfg_took <= cfg_valid && cfg_ready;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // learn successful dynamic maps from the result stream, for unmap and translate
  always @(posedge clk) begin
    if (out_valid && !out_stall && out_status == ST_OK && !out_direct_hit &&
        out_result_addr != 0 && out_cmd_va != 0)
      live_maps.push_back('{out_cmd_va, out_cmd_pages});
  end

  // result side back-pressure: a random stall ahead of each result unless no_gaps is set
  initial begin
    int k;
    @(posedge rst_n);
    forever begin
      k = no_gaps ? 0 : $urandom_range(0, 3);
      if (k != 0) begin
        @(negedge clk) out_stall <= 1;
        repeat (k) @(negedge clk);
        out_stall <= 0;
      end
      @(negedge clk);
      while (!out_took) @(negedge clk);
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  // one request; valid stays high into the next request when there is no gap
  task automatic send_request(logic [1:0] kind, logic [47:0] addr, logic [31:0] len,
                              logic [7:0] fl, logic force_it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1;
    in_req_type  <= kind;
    in_address   <= addr;
    in_length    <= len;
    in_map_flags <= fl;
    in_force_map <= force_it;
    @(negedge clk);
    while (!in_took) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [47:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_took) @(negedge clk);
  endtask

  // stop sending and wait until every result is back and the engine has settled
  task automatic drain();
    in_valid <= 0;
    cfg_valid <= 0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_window(logic [47:0] ps, logic [47:0] pe, logic [47:0] vb,
                            logic [47:0] ds, logic [47:0] de);
    write_reg(CFG_DIRECT_PA_START, ps);
    write_reg(CFG_DIRECT_PA_END, pe);
    write_reg(CFG_DIRECT_VA_BASE, vb);
    write_reg(CFG_DYN_VA_START, ds);
    write_reg(CFG_DYN_VA_END, de);
    cfg_valid <= 0;
    @(negedge clk);
    cur_pa_start = ps;
    cur_pa_end = pe;
    cur_va_base = vb;
    live_maps.delete();
  endtask

  // one random request, biased toward meaningful map / unmap / translate sequences
  task automatic random_request(int map_pct);
    int pick, idx;
    logic [47:0] addr;
    logic [31:0] len;
    logic [1:0] kind;
    live_map_t m;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 20000);
    addr = rand48();
    if (pick < 2) begin
      kind = REQ_UNKNOWN;
    end else if (pick < map_pct) begin
      kind = REQ_MAP;
      case ($urandom_range(0, 3))
        0: addr = rand48();
        1: addr = cur_pa_start + 48'($urandom & 32'h3FFF_FFFF);
        2: addr = {36'd0, 12'(0)} | (48'($urandom_range(0, 15)) << 12) | 48'($urandom_range(0, 4095));
        default: addr = {16'd0, $urandom};
      endcase
    end else if (pick < map_pct + (100 - map_pct) / 2) begin
      kind = REQ_UNMAP;
      idx = $urandom_range(0, 9);
      if (live_maps.size() != 0 && idx < 7) begin
        pick = $urandom_range(0, live_maps.size() - 1);
        m = live_maps[pick];
        live_maps.delete(pick);
        addr = m.va;
        len = 32'({m.pages, 12'd0}) - ((idx == 6) ? 32'd4096 : 32'd0);
      end else if (idx < 8) begin
        addr = cur_va_base + 48'($urandom & 32'h3FFF_F000);
      end
    end else begin
      kind = REQ_TRANSLATE;
      idx = $urandom_range(0, 9);
      if (live_maps.size() != 0 && idx < 6) begin
        m = live_maps[$urandom_range(0, live_maps.size() - 1)];
        addr = m.va + 48'($urandom_range(0, {m.pages, 12'd0}));
      end else if (idx < 8) begin
        addr = cur_va_base + 48'($urandom & 32'h3FFF_FFFF);
      end
    end
    send_request(kind, addr, len, 8'($urandom), 1'($urandom));
  endtask

  task automatic random_phase(int count, int map_pct);
    repeat (count) random_request(map_pct);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed part under the default windows
    send_request(REQ_MAP, 48'h0000_0000_1234, 32'd100, 8'hFF, 0);     // direct window hit
    send_request(REQ_MAP, 48'h0000_3FFF_FFFF, 32'd0, 8'h01, 0);       // last direct page
    send_request(REQ_MAP, 48'h0000_4000_0000, 32'd100, 8'hA5, 0);     // first dynamic run
    send_request(REQ_MAP, 48'h0000_4000_0000, 32'd100, 8'h5A, 0);     // duplicate run
    send_request(REQ_MAP, 48'h0000_0000_1000, 32'd0, 8'h00, 1);       // forced, zero pages
    send_request(REQ_MAP, 48'h0000_0000_2FFF, 32'd1, 8'h80, 1);       // offset plus length fills one page
    send_request(REQ_MAP, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1); // largest: out of va
    send_request(REQ_TRANSLATE, 48'h0000_C000_1234, 0, 0, 0);         // direct translate
    send_request(REQ_TRANSLATE, 48'h0000_4000_0063, 0, 0, 0);         // inside a run
    send_request(REQ_TRANSLATE, 48'h0000_4000_1000, 0, 0, 0);         // past the first run, start of the next
    send_request(REQ_TRANSLATE, 48'h0000_0000_0000, 0, 0, 0);         // not mapped
    send_request(REQ_TRANSLATE, 48'hFFFF_FFFF_FFFF, 0, 0, 0);
    send_request(REQ_UNKNOWN, 48'h0000_4000_0000, 32'd4096, 8'hFF, 1); // ignored
    send_request(REQ_UNMAP, 48'h0000_C000_0000, 32'd4096, 0, 0);      // direct unmap
    send_request(REQ_UNMAP, 48'h0000_4000_0000, 32'd8192, 0, 0);      // wrong length
    send_request(REQ_UNMAP, 48'h0000_4000_0000, 32'd4096, 0, 0);      // exact run
    send_request(REQ_UNMAP, 48'h0000_4000_0000, 32'd4096, 0, 0);      // already gone
    send_request(REQ_UNMAP, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    random_phase(380, 50);
    drain();

    // wide direct window, unaligned dynamic start and a tiny region: out of va often
    set_window(48'h0000_1000_0123, 48'hFFFF_FFFF_FFFF, 48'd0,
               48'h0000_4000_0801, 48'h0000_4020_0801);
    no_gaps = 1;
    random_phase(450, 60);
    no_gaps = 0;
    drain();

    // inverted window never hits, whole space dynamic: fill the table
    set_window(48'hFFFF_FFFF_FFFF, 48'd0, 48'hFFFF_FFFF_FFFF, 48'd0, 48'hFFFF_FFFF_FFFF);
    random_phase(550, 88);
    drain();

    // region and window at the very top of the address space
    set_window(48'd0, 48'h0000_4000_0000, 48'hFFFF_C000_0000,
               48'hFFFF_0000_0000, 48'hFFFF_FFFF_F000);
    random_phase(550, 45);
    drain();

    if (fail_count == 0 && awaiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
